[hdl/fds_pkg.sv]
// ----------------------------------------------------------------------------
// Frame difference statistics package
// Shared widths, command codes, flag layout and the histogram request word.
// ----------------------------------------------------------------------------
package fds_pkg;

  localparam int CHAN_W    = 8;
  localparam int CMD_W     = 2;
  localparam int SIZE_W    = 13;
  localparam int IDX_W     = 1;
  localparam int COUNT_W   = 25;
  localparam int SUM_W     = 34;
  localparam int PIXSUM_W  = 10;
  localparam int NUM_BINS  = 256;
  localparam int BIN_AW    = 8;

  typedef enum logic [CMD_W-1:0] {
    CMD_PIXEL      = 2'd0,
    CMD_READ_BIN   = 2'd1,
    CMD_CLEAR_HIST = 2'd2,
    CMD_NONE       = 2'd3
  } cmd_t;

  typedef enum logic {
    KIND_TOTALS = 1'b0,
    KIND_BIN    = 1'b1
  } kind_t;

  localparam logic [IDX_W-1:0] REG_WIDTH  = 1'd0;
  localparam logic [IDX_W-1:0] REG_HEIGHT = 1'd1;

  typedef enum logic [1:0] {
    HOP_INC   = 2'd0,
    HOP_READ  = 2'd1,
    HOP_CLEAR = 2'd2
  } hist_op_t;

  typedef struct packed {
    logic              en;
    hist_op_t          op;
    logic [BIN_AW-1:0] addr;
  } hist_req_t;

  // Bit 0 marks a differing pixel, bit 1 marks one that has a differing neighbor.
  typedef logic [1:0] flag_t;
  localparam int FLAG_DIFF    = 0;
  localparam int FLAG_TOUCHED = 1;

  function automatic logic [CHAN_W-1:0] abs_diff(input logic [CHAN_W-1:0] a,
                                                 input logic [CHAN_W-1:0] b);
    return (a > b) ? (a - b) : (b - a);
  endfunction

endpackage

[hdl/fds_channels.sv]
// ----------------------------------------------------------------------------
// Frame difference statistics channels
// Valid/ready interfaces for the pixel, result and register write channels.
// ----------------------------------------------------------------------------
interface fds_pixel_if import fds_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  cmd;
  logic [CHAN_W-1:0] first_red;
  logic [CHAN_W-1:0] first_green;
  logic [CHAN_W-1:0] first_blue;
  logic [CHAN_W-1:0] second_red;
  logic [CHAN_W-1:0] second_green;
  logic [CHAN_W-1:0] second_blue;
  logic [BIN_AW-1:0] bin_index;

  modport source (output valid, cmd, first_red, first_green, first_blue,
                  second_red, second_green, second_blue, bin_index, input ready);
  modport sink (input valid, cmd, first_red, first_green, first_blue,
                second_red, second_green, second_blue, bin_index, output ready);
endinterface

interface fds_result_if import fds_pkg::*; #(parameter int BIN_BITS = 40) ();
  logic                valid;
  logic                ready;
  logic                reply_kind;
  logic [COUNT_W-1:0]  differing_pixels;
  logic [CHAN_W-1:0]   largest_channel_difference;
  logic [SUM_W-1:0]    channel_difference_sum;
  logic [COUNT_W-1:0]  isolated_pixels;
  logic [BIN_BITS-1:0] bin_count;

  modport source (output valid, reply_kind, differing_pixels, largest_channel_difference,
                  channel_difference_sum, isolated_pixels, bin_count, input ready);
  modport sink (input valid, reply_kind, differing_pixels, largest_channel_difference,
                channel_difference_sum, isolated_pixels, bin_count, output ready);
endinterface

interface fds_cfg_if import fds_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [IDX_W-1:0]  index;
  logic [SIZE_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

[hdl/fds_ram.sv]
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module fds_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[hdl/fds_hist.sv]
// ----------------------------------------------------------------------------
// Difference histogram
// Bin memory with valid bits, read-modify-write increment and bypass.
// ----------------------------------------------------------------------------
module fds_hist import fds_pkg::*; #(
  parameter int BIN_BITS = 40
) (
  input  logic                clk,
  input  logic                rst,
  input  hist_req_t           req,
  output logic [BIN_BITS-1:0] count
);

  logic [NUM_BINS-1:0] valid_bits;
  logic                pend_inc;
  logic [BIN_AW-1:0]   pend_addr;
  logic                hit;
  logic [BIN_BITS-1:0] hit_data;
  logic                sel_valid;
  logic [BIN_BITS-1:0] rdata;
  logic [BIN_BITS-1:0] inc_value;
  logic                rd_req;

  assign rd_req    = req.en && (req.op != HOP_CLEAR);
  assign count     = hit ? hit_data : (sel_valid ? rdata : '0);
  assign inc_value = (&count) ? count : count + BIN_BITS'(1);

  fds_ram #(.WIDTH(BIN_BITS), .DEPTH(NUM_BINS)) u_bins (
    .clk   (clk),
    .we    (pend_inc),
    .waddr (pend_addr),
    .wdata (inc_value),
    .re    (rd_req),
    .raddr (req.addr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_bits <= '0;
      pend_inc   <= 1'b0;
      pend_addr  <= '0;
      hit        <= 1'b0;
      sel_valid  <= 1'b0;
    end else begin
      pend_inc <= req.en && (req.op == HOP_INC);
      if (rd_req) begin
        pend_addr <= req.addr;
        hit       <= pend_inc && (pend_addr == req.addr);
        hit_data  <= inc_value;
        sel_valid <= valid_bits[req.addr];
      end
      if (req.en && req.op == HOP_CLEAR) begin
        valid_bits <= '0;
      end else if (pend_inc) begin
        valid_bits[pend_addr] <= 1'b1;
      end
    end
  end

  a_no_bin_zero: assert property (@(posedge clk) disable iff (rst)
    pend_inc |-> pend_addr != '0)
    else $error("increment of bin zero");

  a_clear: assert property (@(posedge clk) disable iff (rst)
    req.en && req.op == HOP_CLEAR |=> valid_bits == '0)
    else $error("clear left valid bins");

  a_mark: assert property (@(posedge clk) disable iff (rst)
    pend_inc && !(req.en && req.op == HOP_CLEAR) |=> valid_bits[$past(pend_addr)])
    else $error("written bin not marked valid");

endmodule

[hdl/frame_difference_statistics_top.sv]
// ----------------------------------------------------------------------------
// Frame difference statistics
// Per-frame difference totals, isolated pixel count and a difference histogram.
// ----------------------------------------------------------------------------
// The pixels channel carries one word per pixel pair in raster order, or a
// histogram command: read one bin, or clear all bins. The results channel
// returns frame totals after the last pixel of each frame and one word per bin
// read. The cfg channel writes the frame width and height; a write restarts
// the frame in progress; the user must write cfg only while the block is idle,
// as the block itself does not enforce it. One word is accepted per cycle
// unless results stall. Results go via the holding stage to the output
// register; the histogram increment is a read-modify-write with bypass for
// back-to-back bins. Previous-row flags live in a one-row memory read one
// column ahead of the current pixel. After reset the size is one by one, the
// histogram is empty and no clearing pass is needed. When the receiver stalls,
// one more result waits in a holding stage and then pixels stops taking words.
// ----------------------------------------------------------------------------
module frame_difference_statistics_top import fds_pkg::*; #(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096,
  parameter int BIN_BITS   = 40
) (
  input  logic  clk,
  input  logic  rst,
  fds_pixel_if.sink    pixels,
  fds_result_if.source results,
  fds_cfg_if.sink      cfg
);

  localparam int XW = $clog2(MAX_WIDTH);
  localparam int YW = $clog2(MAX_HEIGHT);

  logic [XW-1:0] px, px_next, last_col;
  logic [YW-1:0] py, py_next, last_row;
  flag_t         a_l, a_c, left, col0, tail, col0_next;
  logic          rfwd_hit;
  flag_t         rfwd_data;
  flag_t         row_rdata;

  logic [COUNT_W-1:0] diff_count, diff_count_next;
  logic [CHAN_W-1:0]  max_seen, max_seen_next;
  logic [SUM_W-1:0]   sum_seen, sum_seen_next;
  logic [COUNT_W-1:0] isolated_count, isolated_next;

  logic               s1_valid, s1_move, s1_load;
  kind_t              s1_kind;
  logic [COUNT_W-1:0] s1_diff, s1_iso;
  logic [CHAN_W-1:0]  s1_max;
  logic [SUM_W-1:0]   s1_sum;

  logic [BIN_BITS-1:0] bin_value;
  hist_req_t           hreq;

  cmd_t              cmd;
  logic              in_acc, cfg_acc, is_pix;
  logic [CHAN_W-1:0] dr, dg, db, m;
  logic [PIXSUM_W-1:0] s;
  logic              d, top, any, row_end, frame_end;
  flag_t             nl, pl, pc, pr, ram_val, nl_upd, pl_upd, pc_upd, pr_upd, cur;
  logic [3:0]        hit, newt;
  logic              row_we;
  logic [XW-1:0]     row_waddr, row_raddr;

  assign cmd     = cmd_t'(pixels.cmd);
  assign in_acc  = pixels.valid && pixels.ready;
  assign cfg_acc = cfg.valid && cfg.ready;
  assign is_pix  = in_acc && (cmd == CMD_PIXEL);
  assign cfg.ready = 1'b1;

  assign dr = abs_diff(pixels.first_red, pixels.second_red);
  assign dg = abs_diff(pixels.first_green, pixels.second_green);
  assign db = abs_diff(pixels.first_blue, pixels.second_blue);
  assign s  = PIXSUM_W'(dr) + PIXSUM_W'(dg) + PIXSUM_W'(db);

  always_comb begin
    m = dr;
    if (dg > m) begin
      m = dg;
    end
    if (db > m) begin
      m = db;
    end
  end

  assign d         = (m != '0);
  assign top       = (py != '0);
  assign row_end   = (px == last_col);
  assign frame_end = row_end && (py == last_row);

  // Neighbor window: left in this row, and three columns of the row above.
  assign ram_val = rfwd_hit ? rfwd_data : row_rdata;
  assign nl = (px != '0) ? left : '0;
  assign pl = top ? a_l : '0;
  assign pc = top ? a_c : '0;
  assign pr = (!top || row_end) ? '0 :
              ((px + XW'(1)) == last_col) ? tail : ram_val;

  assign hit  = {d & pr[FLAG_DIFF], d & pc[FLAG_DIFF], d & pl[FLAG_DIFF], d & nl[FLAG_DIFF]};
  assign newt = hit & ~{pr[FLAG_TOUCHED], pc[FLAG_TOUCHED], pl[FLAG_TOUCHED], nl[FLAG_TOUCHED]};
  assign any  = |hit;
  assign nl_upd = nl | {hit[0], 1'b0};
  assign pl_upd = pl | {hit[1], 1'b0};
  assign pc_upd = pc | {hit[2], 1'b0};
  assign pr_upd = pr | {hit[3], 1'b0};
  assign cur    = d ? {any, 1'b1} : 2'b00;

  always_comb begin
    col0_next = col0;
    if (px == '0 && last_col == '0) begin
      col0_next = cur;
    end else if (px == XW'(1)) begin
      col0_next = nl_upd;
    end
  end

  always_comb begin
    px_next = px;
    py_next = py;
    if (cfg_acc) begin
      px_next = '0;
      py_next = '0;
    end else if (is_pix) begin
      if (row_end) begin
        px_next = '0;
        py_next = frame_end ? '0 : py + YW'(1);
      end else begin
        px_next = px + XW'(1);
      end
    end
  end

  assign row_we    = is_pix && (px != '0);
  assign row_waddr = px - XW'(1);
  assign row_raddr = px_next + XW'(1);

  fds_ram #(.WIDTH($bits(flag_t)), .DEPTH(MAX_WIDTH)) u_row (
    .clk   (clk),
    .we    (row_we),
    .waddr (row_waddr),
    .wdata (nl_upd),
    .re    (1'b1),
    .raddr (row_raddr),
    .rdata (row_rdata)
  );

  assign diff_count_next = diff_count + COUNT_W'(d);
  assign sum_seen_next   = sum_seen + SUM_W'(s);
  assign max_seen_next   = (m > max_seen) ? m : max_seen;
  assign isolated_next   = isolated_count + COUNT_W'(d && !any) - COUNT_W'($countones(newt));

  always_comb begin
    hreq = '{en: 1'b0, op: HOP_READ, addr: pixels.bin_index};
    if (in_acc) begin
      case (cmd)
        CMD_PIXEL: begin
          hreq = '{en: d, op: HOP_INC, addr: m};
        end
        CMD_READ_BIN: begin
          hreq = '{en: 1'b1, op: HOP_READ, addr: pixels.bin_index};
        end
        CMD_CLEAR_HIST: begin
          hreq = '{en: 1'b1, op: HOP_CLEAR, addr: pixels.bin_index};
        end
        default: begin
          hreq = '{en: 1'b0, op: HOP_READ, addr: pixels.bin_index};
        end
      endcase
    end
  end

  fds_hist #(.BIN_BITS(BIN_BITS)) u_hist (
    .clk   (clk),
    .rst   (rst),
    .req   (hreq),
    .count (bin_value)
  );

  assign s1_move = s1_valid && (!results.valid || results.ready);
  assign pixels.ready = !s1_valid || s1_move;
  assign s1_load = in_acc && ((cmd == CMD_READ_BIN) || (cmd == CMD_PIXEL && frame_end));

  always_ff @(posedge clk) begin
    if (rst) begin
      px             <= '0;
      py             <= '0;
      last_col       <= '0;
      last_row       <= '0;
      a_l            <= '0;
      a_c            <= '0;
      left           <= '0;
      col0           <= '0;
      tail           <= '0;
      rfwd_hit       <= 1'b0;
      diff_count     <= '0;
      max_seen       <= '0;
      sum_seen       <= '0;
      isolated_count <= '0;
      s1_valid       <= 1'b0;
      results.valid  <= 1'b0;
    end else begin
      px        <= px_next;
      py        <= py_next;
      rfwd_hit  <= row_we && (row_waddr == row_raddr);
      rfwd_data <= nl_upd;

      if (cfg_acc) begin
        if (cfg.index == REG_WIDTH) begin
          if (cfg.data == '0) begin
            last_col <= '0;
          end else if (32'(cfg.data) > MAX_WIDTH) begin
            last_col <= XW'(MAX_WIDTH - 1);
          end else begin
            last_col <= XW'(cfg.data - SIZE_W'(1));
          end
        end else begin
          if (cfg.data == '0) begin
            last_row <= '0;
          end else if (32'(cfg.data) > MAX_HEIGHT) begin
            last_row <= YW'(MAX_HEIGHT - 1);
          end else begin
            last_row <= YW'(cfg.data - SIZE_W'(1));
          end
        end
        diff_count     <= '0;
        max_seen       <= '0;
        sum_seen       <= '0;
        isolated_count <= '0;
      end else if (is_pix) begin
        col0 <= col0_next;
        if (row_end) begin
          tail <= cur;
          a_l  <= '0;
          a_c  <= col0_next;
          left <= '0;
        end else begin
          a_l  <= pc_upd;
          a_c  <= pr_upd;
          left <= cur;
        end
        if (frame_end) begin
          diff_count     <= '0;
          max_seen       <= '0;
          sum_seen       <= '0;
          isolated_count <= '0;
        end else begin
          diff_count     <= diff_count_next;
          max_seen       <= max_seen_next;
          sum_seen       <= sum_seen_next;
          isolated_count <= isolated_next;
        end
      end

      if (s1_load) begin
        s1_valid <= 1'b1;
      end else if (s1_move) begin
        s1_valid <= 1'b0;
      end

      if (s1_move) begin
        results.valid <= 1'b1;
      end else if (results.ready) begin
        results.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_kind <= (cmd == CMD_READ_BIN) ? KIND_BIN : KIND_TOTALS;
      s1_diff <= diff_count_next;
      s1_max  <= max_seen_next;
      s1_sum  <= sum_seen_next;
      s1_iso  <= isolated_next;
    end
    if (s1_move) begin
      results.reply_kind <= s1_kind;
      if (s1_kind == KIND_BIN) begin
        results.differing_pixels           <= '0;
        results.largest_channel_difference <= '0;
        results.channel_difference_sum     <= '0;
        results.isolated_pixels            <= '0;
        results.bin_count                  <= bin_value;
      end else begin
        results.differing_pixels           <= s1_diff;
        results.largest_channel_difference <= s1_max;
        results.channel_difference_sum     <= s1_sum;
        results.isolated_pixels            <= s1_iso;
        results.bin_count                  <= '0;
      end
    end
  end

  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    in_acc && s1_valid |-> s1_move)
    else $error("holding stage overwritten");

  a_position: assert property (@(posedge clk) disable iff (rst)
    px <= last_col && py <= last_row)
    else $error("raster position outside frame");

  a_totals: assert property (@(posedge clk) disable iff (rst)
    is_pix && frame_end |=> s1_valid && s1_kind == KIND_TOTALS)
    else $error("frame end produced no totals");

endmodule

[tb/fds_checker.sv]
// ----------------------------------------------------------------------------
// Frame difference statistics checker
// Watches the pixel, register and result channels, tracks the frame state and
// the difference histogram, and compares every result word with its prediction.
// ----------------------------------------------------------------------------
module fds_checker import fds_pkg::*; #(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096,
  parameter int BIN_BITS   = 40
) (
  input logic clk,
  input logic rst,
  fds_pixel_if.sink    pixels,
  fds_result_if.sink   results,
  fds_cfg_if.sink      cfg,
  output int           failures,
  output int           pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic                kind;
    logic [COUNT_W-1:0]  diffs;
    logic [CHAN_W-1:0]   peak;
    logic [SUM_W-1:0]    total;
    logic [COUNT_W-1:0]  lone;
    logic [BIN_BITS-1:0] count;
  } reply_t;

  reply_t replies_due[$];
  logic [SIZE_W-1:0] width_reg, height_reg;
  int unsigned col, row;
  logic [1:0] flags [2*MAX_WIDTH];
  logic [COUNT_W-1:0] diff_cnt, lone_cnt;
  logic [CHAN_W-1:0] peak_seen;
  logic [SUM_W-1:0] sum_acc;
  logic [BIN_BITS-1:0] histogram [NUM_BINS];

  assign pending = replies_due.size();

  function automatic int unsigned clamp(int unsigned v, int unsigned hi);
    if (v == 0) return 1;
    return (v > hi) ? hi : v;
  endfunction

  function automatic logic [7:0] chan_delta(logic [7:0] a, logic [7:0] b);
    return (a > b) ? a - b : b - a;
  endfunction

  function automatic void new_frame();
    col = 0; row = 0; diff_cnt = '0; lone_cnt = '0; peak_seen = '0; sum_acc = '0;
  endfunction

  function automatic bit touch(int unsigned idx);
    if (!flags[idx][FLAG_DIFF]) return 0;
    if (!flags[idx][FLAG_TOUCHED]) begin
      flags[idx][FLAG_TOUCHED] = 1'b1;
      lone_cnt--;
    end
    return 1;
  endfunction

  function automatic void account_word();
    int unsigned w, h, x, y, cur, prv, m, s, d;
    bit any;
    reply_t r;
    logic [7:0] a [3], b [3];
    r = '{default: '0};
    case (cmd_t'(pixels.cmd))
      CMD_READ_BIN: begin
        r.kind = KIND_BIN;
        r.count = histogram[pixels.bin_index];
        replies_due.push_back(r);
      end
      CMD_CLEAR_HIST: foreach (histogram[i]) histogram[i] = '0;
      CMD_PIXEL: begin
        a = '{pixels.first_red, pixels.first_green, pixels.first_blue};
        b = '{pixels.second_red, pixels.second_green, pixels.second_blue};
        w = clamp(width_reg, MAX_WIDTH);
        h = clamp(height_reg, MAX_HEIGHT);
        x = (col >= w) ? w - 1 : col;
        y = (row >= h) ? h - 1 : row;
        m = 0; s = 0;
        for (int c = 0; c < 3; c++) begin
          d = chan_delta(a[c], b[c]);
          if (d > m) m = d;
          s += d;
        end
        cur = (y & 1) * MAX_WIDTH;
        prv = ((y & 1) ^ 1) * MAX_WIDTH;
        if (m != 0) begin
          any = 0;
          diff_cnt++;
          sum_acc += s;
          if (m > peak_seen) peak_seen = m;
          if (histogram[m] != '1) histogram[m]++;
          if (x > 0 && touch(cur + x - 1)) any = 1;
          if (y > 0) begin
            if (x > 0 && touch(prv + x - 1)) any = 1;
            if (touch(prv + x)) any = 1;
            if (x + 1 < w && touch(prv + x + 1)) any = 1;
          end
          if (any) begin
            flags[cur + x] = 2'b11;
          end else begin
            flags[cur + x] = 2'b01;
            lone_cnt++;
          end
        end else begin
          flags[cur + x] = 2'b00;
        end
        x++;
        if (x >= w) begin
          x = 0;
          y++;
        end
        col = x; row = y;
        if (y >= h) begin
          r.kind = KIND_TOTALS;
          r.diffs = diff_cnt; r.peak = peak_seen; r.total = sum_acc; r.lone = lone_cnt;
          replies_due.push_back(r);
          new_frame();
        end
      end
      default: ;
    endcase
  endfunction

  task automatic report(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
    failures++;
  endtask

  always @(posedge clk) begin
    reply_t e;
    if (rst) begin
      width_reg = 1; height_reg = 1;
      foreach (flags[i]) flags[i] = '0;
      foreach (histogram[i]) histogram[i] = '0;
      new_frame();
      failures = 0;
    end else begin
      if (results.valid && results.ready) begin
        if (replies_due.size() == 0) begin
          report("unexpected result word", results.reply_kind, 0);
        end else begin
          e = replies_due.pop_front();
          if (results.reply_kind !== e.kind) report("reply_kind", results.reply_kind, e.kind);
          if (results.differing_pixels !== e.diffs)
            report("differing_pixels", results.differing_pixels, e.diffs);
          if (results.largest_channel_difference !== e.peak)
            report("largest_channel_difference", results.largest_channel_difference, e.peak);
          if (results.channel_difference_sum !== e.total)
            report("channel_difference_sum", results.channel_difference_sum, e.total);
          if (results.isolated_pixels !== e.lone)
            report("isolated_pixels", results.isolated_pixels, e.lone);
          if (results.bin_count !== e.count) report("bin_count", results.bin_count, e.count);
        end
      end
      if (cfg.valid && cfg.ready) begin
        if (cfg.index == REG_WIDTH) width_reg = cfg.data;
        else height_reg = cfg.data;
        new_frame();
      end
      if (pixels.valid && pixels.ready) account_word();
    end
  end
endmodule

[tb/frame_difference_statistics_top_tb.sv]
// ----------------------------------------------------------------------------
// Frame difference statistics testbench
// Drives directed and random pixel words and histogram commands over several
// frame sizes with random idling, a long receiver stall and register writes
// between phases; a checker predicts and compares every result word.
// ----------------------------------------------------------------------------
module frame_difference_statistics_top_tb;
  import fds_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG = 20000;

  logic clk, rst;
  int failures, pending;
  int send_idle, recv_idle;
  int hold_cycles;
  int held;
  int quiet;
  bit done;

  fds_pixel_if pixels();
  fds_result_if #(.BIN_BITS(40)) results();
  fds_cfg_if cfg();

  frame_difference_statistics_top DUT (
    .clk(clk), .rst(rst), .pixels(pixels), .results(results), .cfg(cfg)
  );

  fds_checker CHECK (
    .clk(clk), .rst(rst), .pixels(pixels), .results(results), .cfg(cfg),
    .failures(failures), .pending(pending)
  );

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  always @(negedge clk) begin
    if (held < hold_cycles) begin
      results.ready <= 1'b0;
      held <= held + 1;
    end else begin
      results.ready <= ($urandom_range(99) >= recv_idle);
    end
  end

  always @(posedge clk) begin
    if (rst || done || (pixels.valid && pixels.ready) || (results.valid && results.ready)
        || (cfg.valid && cfg.ready)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
    end
    if (quiet > WATCHDOG) begin
      $display("frame_difference_statistics_top_tb failed");
      $finish;
    end
  end

  task automatic send_word(cmd_t c, logic [7:0] fr, fg, fb, sr, sg, sb, logic [7:0] bin);
    while ($urandom_range(99) < send_idle) begin
      pixels.valid <= 1'b0;
      @(negedge clk);
    end
    pixels.valid <= 1'b1;
    pixels.cmd <= c;
    pixels.first_red <= fr; pixels.first_green <= fg; pixels.first_blue <= fb;
    pixels.second_red <= sr; pixels.second_green <= sg; pixels.second_blue <= sb;
    pixels.bin_index <= bin;
    @(posedge clk);
    while (!pixels.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_random_pixel(int odds);
    logic [7:0] fr, fg, fb;
    fr = $urandom; fg = $urandom; fb = $urandom;
    if ($urandom_range(99) < odds) begin
      send_word(CMD_PIXEL, fr, fg, fb, $urandom, $urandom, $urandom, $urandom);
    end else begin
      send_word(CMD_PIXEL, fr, fg, fb, fr, fg, fb, $urandom);
    end
  endtask

  task automatic write_reg(logic [IDX_W-1:0] idx, logic [SIZE_W-1:0] value);
    pixels.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data <= value;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    @(negedge clk);
    cfg.valid <= 1'b0;
  endtask

  task automatic random_frames(int words);
    int r;
    for (int i = 0; i < words; i++) begin
      r = $urandom_range(99);
      if (r < 6) send_word(CMD_READ_BIN, $urandom, $urandom, $urandom, $urandom,
                           $urandom, $urandom, $urandom);
      else if (r < 7) send_word(CMD_CLEAR_HIST, $urandom, $urandom, $urandom, $urandom,
                                $urandom, $urandom, $urandom);
      else if (r < 8) send_word(CMD_NONE, $urandom, $urandom, $urandom, $urandom,
                                $urandom, $urandom, $urandom);
      else send_random_pixel((i % 3 == 0) ? 15 : 50);
    end
  endtask

  initial begin
    rst = 1;
    done = 0;
    hold_cycles = 0;
    quiet = 0;
    send_idle = 29;
    recv_idle = 59;
    pixels.valid = 0; pixels.cmd = CMD_PIXEL;
    pixels.first_red = 0; pixels.first_green = 0; pixels.first_blue = 0;
    pixels.second_red = 0; pixels.second_green = 0; pixels.second_blue = 0;
    pixels.bin_index = 0;
    results.ready = 0;
    cfg.valid = 0; cfg.index = REG_WIDTH; cfg.data = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 0;

    send_word(CMD_PIXEL, 8'd0, 8'd0, 8'd0, 8'd255, 8'd255, 8'd255, 8'd0);
    send_word(CMD_PIXEL, 8'd255, 8'd0, 8'd255, 8'd0, 8'd255, 8'd0, 8'd0);
    send_word(CMD_PIXEL, 8'd7, 8'd7, 8'd7, 8'd7, 8'd7, 8'd7, 8'd0);
    send_word(CMD_READ_BIN, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd255);
    send_word(CMD_READ_BIN, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
    send_word(CMD_NONE, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff);
    send_word(CMD_CLEAR_HIST, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
    send_word(CMD_READ_BIN, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd255);

    write_reg(REG_WIDTH, 13'd3);
    write_reg(REG_HEIGHT, 13'd3);
    for (int i = 0; i < 9; i++) begin
      if (i == 0 || i == 4 || i == 8 || i == 2) begin
        send_word(CMD_PIXEL, 8'd10, 8'd20, 8'd30, 8'd11, 8'd20, 8'd30, 8'd0);
      end else begin
        send_word(CMD_PIXEL, 8'd10, 8'd20, 8'd30, 8'd10, 8'd20, 8'd30, 8'd0);
      end
    end
    send_word(CMD_READ_BIN, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd1);

    write_reg(REG_WIDTH, 13'd0);
    write_reg(REG_HEIGHT, 13'd0);
    random_frames(40);

    write_reg(REG_WIDTH, 13'd8191);
    write_reg(REG_HEIGHT, 13'd1);
    random_frames(30);
    write_reg(REG_WIDTH, 13'd4);
    random_frames(30);
    write_reg(REG_WIDTH, 13'd4096);
    for (int i = 0; i < 200; i++) send_random_pixel(i < 40 ? 50 : 0);

    write_reg(REG_WIDTH, 13'd5);
    write_reg(REG_HEIGHT, 13'd4);
    random_frames(400);

    send_idle = 59;
    recv_idle = 29;
    write_reg(REG_WIDTH, 13'd1);
    write_reg(REG_HEIGHT, 13'd2);
    random_frames(200);
    write_reg(REG_WIDTH, 13'd7);
    write_reg(REG_HEIGHT, 13'd8191);
    random_frames(150);
    write_reg(REG_HEIGHT, 13'd3);
    random_frames(250);

    send_idle = 0;
    recv_idle = 0;
    write_reg(REG_WIDTH, 13'd2);
    write_reg(REG_HEIGHT, 13'd2);
    hold_cycles = 300;
    random_frames(250);
    write_reg(REG_WIDTH, 13'd6);
    write_reg(REG_HEIGHT, 13'd5);
    random_frames(380);

    pixels.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    done = 1;
    if (failures == 0) begin
      $display("frame_difference_statistics_top_tb passed");
    end else begin
      $display("frame_difference_statistics_top_tb failed");
    end
    $finish;
  end
endmodule
